FILE: rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// Tree extension steer step: shared types and constants
// Item payload carried down the pipeline and fixed arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

    localparam int unsigned COORD_W = 32;  // Q16.16 coordinate
    localparam int unsigned STEP_W  = 31;  // step length register
    localparam int unsigned PROD_W  = 62;  // step length times normalized diff
    localparam int unsigned RAD_W   = 63;  // a^2 + b^2
    localparam int unsigned ROOT_W  = 32;  // floor(sqrt(a^2 + b^2))
    localparam int unsigned QUO_W   = 31;  // per-axis offset magnitude

    // Pass-through fields of one item
    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_z;
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_z;
        logic [STEP_W-1:0]         step;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero_xy;
        logic                      in_reach;
    } item_t;

    // Sideband through the square root: item plus the division numerators
    typedef struct packed {
        item_t             item;
        logic [PROD_W-1:0] prod_x;
        logic [PROD_W-1:0] prod_y;
    } sq_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/tes_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor(sqrt(rad)), sideband travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_isqrt
    import tes_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire sq_side_t          in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output sq_side_t               out_side
);

    logic                  valid_reg [ROOT_W];
    logic [RAD_W:0]        rad_reg   [ROOT_W];
    logic [ROOT_W+1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]     root_reg  [ROOT_W];
    sq_side_t              side_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              v_prev;
        logic [RAD_W:0]    rad_prev;
        logic [ROOT_W+1:0] rem_prev;
        logic [ROOT_W-1:0] root_prev;
        sq_side_t          side_prev;
        logic [ROOT_W+3:0] rem_w;
        logic [ROOT_W+3:0] trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = {1'b0, in_rad};
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end else begin : g_next
            assign v_prev    = valid_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // Bring down the next bit pair and try the trial subtrahend
        assign rem_w = {rem_prev, rad_prev[RAD_W:RAD_W-1]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign take  = (rem_w >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k]  <= {rad_prev[RAD_W-2:0], 2'b00};
                side_reg[k] <= side_prev;
                if (take) begin
                    rem_reg[k]  <= (ROOT_W+2)'(rem_w - trial);
                    root_reg[k] <= {root_prev[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_w[ROOT_W+1:0];
                    root_reg[k] <= {root_prev[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/tes_div.sv
// ----------------------------------------------------------------------------
// Pipelined two-lane restoring divider
// Divides the X and Y numerators by one shared divisor, one quotient bit a
// stage. The quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_div
    import tes_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_num_x,
    input  wire logic [RAD_W-1:0]  in_num_y,
    input  wire logic [ROOT_W-1:0] in_den,
    input  wire item_t             in_item,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       out_quo_x,
    output logic [QUO_W-1:0]       out_quo_y,
    output item_t                  out_item
);

    logic                  valid_reg [QUO_W];
    logic [ROOT_W-1:0]     den_reg   [QUO_W];
    logic [ROOT_W-1:0]     remx_reg  [QUO_W];
    logic [ROOT_W-1:0]     remy_reg  [QUO_W];
    logic [QUO_W-1:0]      lowx_reg  [QUO_W];
    logic [QUO_W-1:0]      lowy_reg  [QUO_W];
    logic [QUO_W-1:0]      qx_reg    [QUO_W];
    logic [QUO_W-1:0]      qy_reg    [QUO_W];
    item_t                 item_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              v_prev;
        logic [ROOT_W-1:0] den_prev;
        logic [ROOT_W-1:0] remx_prev;
        logic [ROOT_W-1:0] remy_prev;
        logic [QUO_W-1:0]  lowx_prev;
        logic [QUO_W-1:0]  lowy_prev;
        logic [QUO_W-1:0]  qx_prev;
        logic [QUO_W-1:0]  qy_prev;
        item_t             item_prev;
        logic [ROOT_W:0]   remx_w;
        logic [ROOT_W:0]   remy_w;
        logic              takex;
        logic              takey;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign den_prev  = in_den;
            assign remx_prev = in_num_x[RAD_W-1:QUO_W];
            assign remy_prev = in_num_y[RAD_W-1:QUO_W];
            assign lowx_prev = in_num_x[QUO_W-1:0];
            assign lowy_prev = in_num_y[QUO_W-1:0];
            assign qx_prev   = '0;
            assign qy_prev   = '0;
            assign item_prev = in_item;
        end else begin : g_next
            assign v_prev    = valid_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign remx_prev = remx_reg[k-1];
            assign remy_prev = remy_reg[k-1];
            assign lowx_prev = lowx_reg[k-1];
            assign lowy_prev = lowy_reg[k-1];
            assign qx_prev   = qx_reg[k-1];
            assign qy_prev   = qy_reg[k-1];
            assign item_prev = item_reg[k-1];
        end

        // Shift in the next numerator bit and compare against the divisor
        assign remx_w = {remx_prev, lowx_prev[QUO_W-1]};
        assign remy_w = {remy_prev, lowy_prev[QUO_W-1]};
        assign takex  = (remx_w >= {1'b0, den_prev});
        assign takey  = (remy_w >= {1'b0, den_prev});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                den_reg[k]  <= den_prev;
                item_reg[k] <= item_prev;
                lowx_reg[k] <= {lowx_prev[QUO_W-2:0], 1'b0};
                lowy_reg[k] <= {lowy_prev[QUO_W-2:0], 1'b0};
                remx_reg[k] <= takex ? ROOT_W'(remx_w - {1'b0, den_prev})
                                     : remx_w[ROOT_W-1:0];
                remy_reg[k] <= takey ? ROOT_W'(remy_w - {1'b0, den_prev})
                                     : remy_w[ROOT_W-1:0];
                qx_reg[k]   <= {qx_prev[QUO_W-2:0], takex};
                qy_reg[k]   <= {qy_prev[QUO_W-2:0], takey};
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo_x = qx_reg[QUO_W-1];
    assign out_quo_y = qy_reg[QUO_W-1];
    assign out_item  = item_reg[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/tree_extend_steer_step.sv
// Throughput: one beat per cycle while the output skid buffer is empty; set by
// the fully pipelined 32-stage square root and 31-stage divider, every stage
// registered.
// Reset (aresetn low, synchronous): pipeline and output buffer empty,
// step_length back to 1.0 (65536).
// ----------------------------------------------------------------------------
// Tree extension steer step
// Clips a sample toward its nearest tree node by the configured step length
// in the XY plane, or passes the sample through when it lies within reach.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_extend_steer_step
    import tes_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Configuration write: step_length
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [30:0]   cfg_data,
    // Input beat
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // sample_x, sample_y, sample_z, near_x, near_y, near_z (from bit 0 up)
    input  wire logic [191:0]  s_tdata,
    // Result beat
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // new_x, new_y, new_z (from bit 0 up)
    output logic [95:0]        m_tdata,
    // was_steered
    output logic [0:0]         m_tuser
);

    localparam logic [ROOT_W-1:0] STEP_RESET = 32'd65536;
    localparam logic signed [COORD_W+1:0] SAT_HI = 34'sh0_7FFF_FFFF;
    localparam logic signed [COORD_W+1:0] SAT_LO = -34'sh0_8000_0000;

    logic                adv;
    logic [STEP_W-1:0]   step_reg;

    // Register write; always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET[STEP_W-1:0];
        end else if (cfg_valid) begin
            step_reg <= cfg_data;
        end
    end

    // ---------------- stage 0: capture the input beat ----------------
    logic   v0_reg;
    item_t  i0_reg;

    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i0_reg.sample_x <= s_tdata[31:0];
            i0_reg.sample_y <= s_tdata[63:32];
            i0_reg.sample_z <= s_tdata[95:64];
            i0_reg.near_x   <= s_tdata[127:96];
            i0_reg.near_y   <= s_tdata[159:128];
            i0_reg.near_z   <= s_tdata[191:160];
            i0_reg.step     <= step_reg;
            i0_reg.neg_x    <= 1'b0;
            i0_reg.neg_y    <= 1'b0;
            i0_reg.zero_xy  <= 1'b0;
            i0_reg.in_reach <= 1'b0;
        end
    end

    // ---------------- stage 1: differences and magnitudes ----------------
    logic signed [COORD_W:0] dx_next, dy_next, dz_next;
    logic [COORD_W:0]        ax_next, ay_next, az_next;
    item_t                   i1_next;
    logic                    v1_reg;
    item_t                   i1_reg;
    logic [COORD_W:0]        ax1_reg, ay1_reg, az1_reg, m1_reg;

    assign dx_next = {i0_reg.sample_x[31], i0_reg.sample_x}
                     - {i0_reg.near_x[31], i0_reg.near_x};
    assign dy_next = {i0_reg.sample_y[31], i0_reg.sample_y}
                     - {i0_reg.near_y[31], i0_reg.near_y};
    assign dz_next = {i0_reg.sample_z[31], i0_reg.sample_z}
                     - {i0_reg.near_z[31], i0_reg.near_z};
    assign ax_next = dx_next[COORD_W] ? (COORD_W+1)'(-dx_next) : dx_next;
    assign ay_next = dy_next[COORD_W] ? (COORD_W+1)'(-dy_next) : dy_next;
    assign az_next = dz_next[COORD_W] ? (COORD_W+1)'(-dz_next) : dz_next;

    // Attach the signs and the zero-heading flag
    always_comb begin
        i1_next         = i0_reg;
        i1_next.neg_x   = dx_next[COORD_W];
        i1_next.neg_y   = dy_next[COORD_W];
        i1_next.zero_xy = (ax_next == '0) && (ay_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i1_reg         <= i1_next;
            ax1_reg        <= ax_next;
            ay1_reg        <= ay_next;
            az1_reg        <= az_next;
            m1_reg         <= (ax_next > ay_next) ? ax_next : ay_next;
        end
    end

    // ---------------- stage 2: squares and normalize amount ----------------
    logic [5:0]          msb_next;
    logic                v2_reg;
    item_t               i2_reg;
    logic [PROD_W-1:0]   sqx2_reg, sqy2_reg, sqz2_reg, step2_reg;
    logic                oor2_reg;
    logic [COORD_W:0]    ax2_reg, ay2_reg;
    logic                shl2_reg;
    logic [4:0]          sh2_reg;

    // Find the leading one of the larger XY magnitude
    always_comb begin
        msb_next = '0;
        for (int i = 0; i <= COORD_W; i++) begin
            if (m1_reg[i]) begin
                msb_next = 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i2_reg    <= i1_reg;
            sqx2_reg  <= ax1_reg[30:0] * ax1_reg[30:0];
            sqy2_reg  <= ay1_reg[30:0] * ay1_reg[30:0];
            sqz2_reg  <= az1_reg[30:0] * az1_reg[30:0];
            step2_reg <= i1_reg.step * i1_reg.step;
            oor2_reg  <= (ax1_reg[32:31] != 2'b00) || (ay1_reg[32:31] != 2'b00)
                         || (az1_reg[32:31] != 2'b00);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            shl2_reg  <= (msb_next <= 6'd30);
            sh2_reg   <= (msb_next <= 6'd30) ? 5'(6'd30 - msb_next)
                                             : 5'(msb_next - 6'd30);
        end
    end

    // ---------------- stage 3: reach test and normalize ----------------
    logic [63:0]        d2_next;
    logic [COORD_W:0]   an_next, bn_next;
    item_t              i3_next;
    logic               v3_reg;
    item_t              i3_reg;
    logic [STEP_W-1:0]  a3_reg, b3_reg;

    assign d2_next = 64'(sqx2_reg) + 64'(sqy2_reg) + 64'(sqz2_reg);
    assign an_next = shl2_reg ? (ax2_reg << sh2_reg) : (ax2_reg >> sh2_reg);
    assign bn_next = shl2_reg ? (ay2_reg << sh2_reg) : (ay2_reg >> sh2_reg);

    // Mark the item as within reach
    always_comb begin
        i3_next          = i2_reg;
        i3_next.in_reach = !oor2_reg && (d2_next < 64'(step2_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i3_reg        <= i3_next;
            a3_reg        <= an_next[STEP_W-1:0];
            b3_reg        <= bn_next[STEP_W-1:0];
        end
    end

    // ---------------- stage 4: products ----------------
    logic               v4_reg;
    item_t              i4_reg;
    logic [PROD_W-1:0]  aa4_reg, bb4_reg, pa4_reg, pb4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i4_reg  <= i3_reg;
            aa4_reg <= a3_reg * a3_reg;
            bb4_reg <= b3_reg * b3_reg;
            pa4_reg <= i3_reg.step * a3_reg;
            pb4_reg <= i3_reg.step * b3_reg;
        end
    end

    // ---------------- stage 5: radicand ----------------
    logic               v5_reg;
    sq_side_t           s5_reg;
    logic [RAD_W-1:0]   rad5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_reg.item   <= i4_reg;
            s5_reg.prod_x <= pa4_reg;
            s5_reg.prod_y <= pb4_reg;
            rad5_reg      <= RAD_W'(aa4_reg) + RAD_W'(bb4_reg);
        end
    end

    // ---------------- square root ----------------
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    sq_side_t           sq_side;

    tes_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_rad    (rad5_reg),
        .in_side   (s5_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---------------- stage 6: rounded numerators ----------------
    logic               v6_reg;
    item_t              i6_reg;
    logic [RAD_W-1:0]   nx6_reg, ny6_reg;
    logic [ROOT_W-1:0]  r6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i6_reg  <= sq_side.item;
            r6_reg  <= sq_root;
            nx6_reg <= RAD_W'(sq_side.prod_x) + RAD_W'(sq_root[ROOT_W-1:1]);
            ny6_reg <= RAD_W'(sq_side.prod_y) + RAD_W'(sq_root[ROOT_W-1:1]);
        end
    end

    // ---------------- divider ----------------
    logic               dv_valid;
    logic [QUO_W-1:0]   dv_qx, dv_qy;
    item_t              dv_item;

    tes_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v6_reg),
        .in_num_x  (nx6_reg),
        .in_num_y  (ny6_reg),
        .in_den    (r6_reg),
        .in_item   (i6_reg),
        .out_valid (dv_valid),
        .out_quo_x (dv_qx),
        .out_quo_y (dv_qy),
        .out_item  (dv_item)
    );

    // ---------------- final: offsets, saturate, select ----------------
    logic [QUO_W-1:0]          mx_next, my_next;
    logic signed [COORD_W+1:0] ox_next, oy_next, sx_next, sy_next;
    logic [COORD_W-1:0]        fx_next, fy_next;
    logic [96:0]               res_next;

    assign mx_next = dv_item.zero_xy ? dv_item.step : dv_qx;
    assign my_next = dv_item.zero_xy ? '0 : dv_qy;
    assign ox_next = dv_item.neg_x ? -$signed({3'b000, mx_next})
                                   : $signed({3'b000, mx_next});
    assign oy_next = dv_item.neg_y ? -$signed({3'b000, my_next})
                                   : $signed({3'b000, my_next});
    assign sx_next = $signed({{2{dv_item.near_x[31]}}, dv_item.near_x}) + ox_next;
    assign sy_next = $signed({{2{dv_item.near_y[31]}}, dv_item.near_y}) + oy_next;

    // Clamp to the Q16.16 range
    always_comb begin
        if (sx_next > SAT_HI) begin
            fx_next = SAT_HI[COORD_W-1:0];
        end else if (sx_next < SAT_LO) begin
            fx_next = SAT_LO[COORD_W-1:0];
        end else begin
            fx_next = sx_next[COORD_W-1:0];
        end
        if (sy_next > SAT_HI) begin
            fy_next = SAT_HI[COORD_W-1:0];
        end else if (sy_next < SAT_LO) begin
            fy_next = SAT_LO[COORD_W-1:0];
        end else begin
            fy_next = sy_next[COORD_W-1:0];
        end
    end

    // {was_steered, new_z, new_y, new_x}
    assign res_next = dv_item.in_reach
        ? {1'b0, dv_item.sample_z, dv_item.sample_y, dv_item.sample_x}
        : {1'b1, dv_item.near_z, fy_next, fx_next};

    // ---------------- output register with skid ----------------
    logic         m_valid_reg, skid_valid_reg;
    logic [96:0]  m_data_reg, skid_data_reg;

    assign adv = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid beat once the output moves
            if (m_tready) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (m_valid_reg && !m_tready) begin
            // hold the output, park a new beat
            if (dv_valid) begin
                skid_data_reg  <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end else begin
            m_valid_reg <= dv_valid;
            m_data_reg  <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg[95:0];
    assign m_tuser  = m_data_reg[96:96];

endmodule

`default_nettype wire

FILE: tb/sv/tree_extend_steer_step_test.sv
// ----------------------------------------------------------------------------
// Tree extension steer step: stream-level testbench
// Drives sample / near-node pairs under several step lengths, predicts each
// new node independently and checks every result beat in order, with bursty
// input, receiver stalls, a long output hold-off and drain-and-reconfigure.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_extend_steer_step_test
    import tes_pkg::*;
;

    localparam int unsigned PERIOD_HI  = 5;
    localparam int unsigned PERIOD_LO  = 5;
    localparam int unsigned LATENCY    = 71;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned CYCLE_CAP  = 500000;
    localparam int unsigned PHASE_ITEMS = 320;
    localparam int unsigned NUM_STEPS  = 6;

    // Stimulus shapes for one pair
    typedef enum int {
        PAIR_ANY, PAIR_CLOSE, PAIR_SAME_XY, PAIR_EXTREME, PAIR_ON_EDGE
    } pair_kind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_z;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] sample_z;
        logic signed [COORD_W-1:0] sample_y;
        logic signed [COORD_W-1:0] sample_x;
    } point_pair_t;

    typedef struct packed {
        logic                      steered;
        logic signed [COORD_W-1:0] new_z;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_x;
    } new_node_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the new node and matches result beats in order
    // ------------------------------------------------------------------------
    class steer_scoreboard;
        logic [STEP_W-1:0] step_len;
        new_node_t         expected_nodes[$];
        int unsigned       mismatches;
        int unsigned       items_in;
        int unsigned       results_out;
        int unsigned       steered_seen;

        function new();
            step_len = 31'd65536;
        endfunction

        static function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        static function logic [COORD_W-1:0] clamp_coord(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[COORD_W-1:0];
        endfunction

        function new_node_t steer_predict(point_pair_t p);
            longint          dx, dy, dz, ox, oy;
            longint unsigned ax, ay, az, lim, a, b, m, r, qx, qy, stp;
            logic            reach;
            new_node_t       n;
            stp = longint'(step_len);
            dx  = longint'(p.sample_x) - longint'(p.near_x);
            dy  = longint'(p.sample_y) - longint'(p.near_y);
            dz  = longint'(p.sample_z) - longint'(p.near_z);
            ax  = dx < 0 ? -dx : dx;
            ay  = dy < 0 ? -dy : dy;
            az  = dz < 0 ? -dz : dz;
            lim = 64'd1 << 31;
            reach = 1'b0;
            if (ax < lim && ay < lim && az < lim)
                reach = (ax * ax + ay * ay + az * az) < stp * stp;
            if (reach) begin
                n.new_x = p.sample_x;
                n.new_y = p.sample_y;
                n.new_z = p.sample_z;
                n.steered = 1'b0;
                return n;
            end
            // Heading from the XY difference, normalized to [2^30, 2^31)
            if (ax == 0 && ay == 0) begin
                ox = longint'(stp);
                oy = 0;
            end else begin
                a = ax;
                b = ay;
                m = a > b ? a : b;
                while (m >= lim) begin
                    a = a >> 1; b = b >> 1; m = m >> 1;
                end
                while (m < (64'd1 << 30)) begin
                    a = a << 1; b = b << 1; m = m << 1;
                end
                r  = floor_sqrt(a * a + b * b);
                qx = (stp * a + (r >> 1)) / r;
                qy = (stp * b + (r >> 1)) / r;
                ox = dx < 0 ? -longint'(qx) : longint'(qx);
                oy = dy < 0 ? -longint'(qy) : longint'(qy);
            end
            n.new_x = clamp_coord(longint'(p.near_x) + ox);
            n.new_y = clamp_coord(longint'(p.near_y) + oy);
            n.new_z = p.near_z;
            n.steered = 1'b1;
            return n;
        endfunction

        function void note_pair(point_pair_t p);
            expected_nodes.insert(expected_nodes.size(), steer_predict(p));
            items_in++;
        endfunction

        function void check_node(logic [95:0] data, logic steered);
            new_node_t want;
            new_node_t got;
            results_out++;
            got = {steered, data};
            if (expected_nodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing expected: %h", got);
                return;
            end
            want = expected_nodes.pop_front();
            if (want.steered) steered_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("node %0d: x %h/%h y %h/%h z %h/%h steered %b/%b (exp/act)",
                             results_out, want.new_x, got.new_x, want.new_y, got.new_y,
                             want.new_z, got.new_z, want.steered, got.steered);
            end
        endfunction
    endclass

    logic          aclk;
    logic          aresetn;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [30:0]   cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [191:0]  s_tdata;   // sample_x, sample_y, sample_z, near_x, near_y, near_z
    logic          m_tvalid;
    logic          m_tready;
    logic [95:0]   m_tdata;   // new_x, new_y, new_z
    logic [0:0]    m_tuser;   // was_steered

    steer_scoreboard sb;
    int unsigned     cyc = 0;
    logic [1:0]      rx_mode;
    logic            hold_request;
    int unsigned     hold_left;
    int unsigned     steps_used;

    tree_extend_steer_step DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #PERIOD_LO aclk = 1'b1;
        #PERIOD_HI aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("FAIL tree_extend_steer_step");
            $finish;
        end
    end

    // Receiver: check accepted beats, stall on a shifting pattern, honor hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            rx_mode   <= 2'd0;
        end else begin
            if (m_tvalid && m_tready) sb.check_node(m_tdata, m_tuser[0]);
            if (cyc[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
            if (hold_request) hold_left <= HOLD_LEN;
            else if (hold_left != 0) hold_left <= hold_left - 1;
            if (hold_request || hold_left > 1) m_tready <= 1'b0;
            else case (rx_mode)
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cyc[2:0] < 3'd5);
            endcase
        end
    end

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Offset near a point by up to a few step lengths, wrapping to 32 bits
    function automatic logic [31:0] nudge(logic [31:0] base, logic [30:0] stp);
        longint unsigned span;
        longint          d;
        span = longint'(stp) * 3 + 2;
        if (span > 64'd2147483647) span = 64'd2147483647;
        d = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
        return 32'(longint'($signed(base)) + d);
    endfunction

    function automatic point_pair_t make_pair(pair_kind_t kind, logic [30:0] stp);
        point_pair_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case (kind)
            PAIR_CLOSE: begin
                p.sample_x = nudge(p.near_x, stp);
                p.sample_y = nudge(p.near_y, stp);
                p.sample_z = nudge(p.near_z, stp);
            end
            PAIR_SAME_XY: begin
                p.sample_x = p.near_x;
                p.sample_y = p.near_y;
                if ($urandom_range(0, 1)) p.sample_z = nudge(p.near_z, stp);
            end
            PAIR_EXTREME: begin
                p = {pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme(), pick_extreme(), pick_extreme()};
            end
            PAIR_ON_EDGE: begin
                // Distance exactly at the step length along one axis, or one short
                p.sample_y = p.near_y;
                p.sample_z = p.near_z;
                p.near_x   = 32'($urandom_range(0, 1) ? -32'sd1000 : 32'sd1000);
                p.sample_x = 32'(longint'($signed(p.near_x)) + longint'(stp)
                                 - longint'($urandom_range(0, 1)));
            end
            default: ;
        endcase
        return p;
    endfunction

    // Offer one pair and hold it until accepted
    task automatic send_pair(point_pair_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(p);
    endtask

    task automatic idle_input(int unsigned n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Wait until every expected result has come back
    task automatic wait_drained();
        while (sb.expected_nodes.size() != 0) @(posedge aclk);
    endtask

    // Drain every result, let the pipe settle, then write the step length
    task automatic write_step(logic [30:0] v);
        idle_input(0);
        wait_drained();
        repeat (LATENCY + 8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.step_len = v;
        steps_used++;
    endtask

    task automatic run_directed();
        point_pair_t p;
        // Identical points, then zero XY with a far Z, then extreme spans
        p = '0;
        send_pair(p);
        p.sample_z = 32'h0010_0000;
        send_pair(p);
        p = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(p);
        send_pair({p[95:0], p[191:96]});
        // Saturate new_x against the top and bottom of the range
        p = '0;
        p.near_x = 32'h7FFF_FFF0;
        p.sample_x = 32'h7FFF_FFF0;
        p.sample_z = 32'h0100_0000;
        send_pair(p);
        p.near_x = 32'h8000_0010;
        p.sample_x = 32'h8000_0000;
        send_pair(p);
        // Each quadrant, one point beyond the reset step length and one within it
        for (int q = 0; q < 4; q++) begin
            p = '0;
            p.sample_x = q[0] ? -32'sd300000 : 32'sd300000;
            p.sample_y = q[1] ? -32'sd70000 : 32'sd70000;
            send_pair(p);
            p.sample_x = q[0] ? -32'sd40000 : 32'sd40000;
            p.sample_y = q[1] ? -32'sd40000 : 32'sd40000;
            send_pair(p);
        end
        for (int k = 0; k < 4; k++) send_pair(make_pair(PAIR_ON_EDGE, sb.step_len));
        for (int k = 0; k < 4; k++) send_pair(make_pair(PAIR_EXTREME, sb.step_len));
    endtask

    task automatic run_random(int unsigned count, bit with_hold);
        int unsigned sent;
        int unsigned burst;
        int unsigned roll;
        pair_kind_t  kind;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            if (with_hold && sent >= count / 3 && sent < count / 3 + burst) begin
                hold_request <= 1'b1;
                idle_input(1);
                hold_request <= 1'b0;
            end
            for (int k = 0; k < burst && sent < count; k++) begin
                roll = $urandom_range(0, 99);
                kind = roll < 30 ? PAIR_ANY : roll < 75 ? PAIR_CLOSE :
                       roll < 85 ? PAIR_SAME_XY : roll < 93 ? PAIR_EXTREME : PAIR_ON_EDGE;
                send_pair(make_pair(kind, sb.step_len));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
        end
    endtask

    // Main sequence
    initial begin
        logic [30:0] step_list [NUM_STEPS];
        sb = new();
        steps_used = 0;
        hold_request = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        step_list = '{31'd1, 31'h7FFF_FFFF, 31'd65536 * 3, 31'd200,
                      31'($urandom_range(1, 32'h7FFF_FFFF)), 31'd65536};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset step length first
        run_directed();
        run_random(PHASE_ITEMS / 2, 1'b0);
        for (int s = 0; s < NUM_STEPS; s++) begin
            write_step(step_list[s]);
            if (s < 2) run_directed();
            run_random(PHASE_ITEMS - (s < 2 ? 24 : 0), s == 2);
        end

        idle_input(0);
        wait_drained();
        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d pairs over %0d step lengths; %0d steered, %0d passed through",
                 sb.items_in, steps_used + 1, sb.steered_seen,
                 sb.results_out - sb.steered_seen);
        if (sb.mismatches == 0 && sb.expected_nodes.size() == 0)
            $display("PASS tree_extend_steer_step");
        else
            $display("FAIL tree_extend_steer_step");
        $finish;
    end

endmodule

`default_nettype wire
